// ----- rtl/core/msrs_pkg.sv -----
`default_nettype none
// ============================================================================
// msrs_pkg
// Shared types and constants of the multipath source route selector: the
// input and result words, the selection mode codes and the register indexes.
// ============================================================================
package msrs_pkg;

    // Field widths
    localparam int DEST_W     = 16;
    localparam int TAG_W      = 32;
    localparam int RAND_W     = 32;
    localparam int UPLINK_W   = 5;
    localparam int INTER_W    = 8;
    localparam int DOWNLINK_W = 13;
    localparam int RACK_W     = 7;
    localparam int HOST_W     = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int MODE_W      = 3;
    localparam int AGG_W       = 8;
    localparam int MID_CNT_W   = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_SELECT_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AGG_COUNT   = 1'd1;

    // Selection modes; unused codes behave as random
    localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RR     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEQ_RR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHARED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAG    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_RR;
    localparam logic [AGG_W-1:0]  AGG_RESET  = 8'd2;
    localparam logic [AGG_W-1:0]  AGG_MIN    = 8'd2;

    // Input word
    typedef struct packed {
        logic [DEST_W-1:0] dest_host;
        logic              tag_present;
        logic [TAG_W-1:0]  path_tag_value;
        logic              random_up_bit;
        logic              random_down_bit;
        logic [RAND_W-1:0] random_word;
    } msrs_in_t;

    // Result word
    typedef struct packed {
        logic [UPLINK_W-1:0]   uplink_port;
        logic [INTER_W-1:0]    intermediate_port;
        logic [DOWNLINK_W-1:0] downlink_port;
        logic [RACK_W-1:0]     rack_port;
        logic [HOST_W-1:0]     host_port;
    } msrs_out_t;

endpackage
`default_nettype wire

// ----- rtl/core/msrs_div.sv -----
`default_nettype none
// ============================================================================
// msrs_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Busy from start until the last quotient bit is shifted in; divisor must be nonzero.
// ============================================================================
module msrs_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- rtl/core/multipath_source_route_selector_top.sv -----
`default_nettype none
// A new input word is accepted only in the idle state, once the result word
// of the previous one is loaded. Two 16-bit serial passes run back to back
// on the host divider (group split beside host, then rack), beside a 32-bit
// serial reducer for the intermediate choice; the result word is loaded once
// both are done. A stalled result word holds the final pass.
// Reset (aresetn, synchronous, active low): select_mode = round robin,
// aggregation_count = 2, all route counters zero, result register empty.
// ============================================================================
// multipath_source_route_selector_top
// Builds a source route per packet: uplink, intermediate, downlink, rack and
// host ports, with five selectable path choice modes.
// ============================================================================
module multipath_source_route_selector_top #(
    parameter int HOSTS_PER_RACK = 20,
    parameter int RACKS_FACTOR   = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration
    input  logic                                  cfg_wr_en,
    input  logic [msrs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [msrs_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    // Input words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  msrs_pkg::msrs_in_t                    s_data,
    // Result words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output msrs_pkg::msrs_out_t                   m_data
);

    import msrs_pkg::*;

    localparam int HPR_W   = $clog2(HOSTS_PER_RACK + 1);
    localparam int GROUP_W = $clog2(RACKS_FACTOR * 255 + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RACK
    } state_t;

    typedef enum logic [1:0] {
        MID_COUNT,
        MID_REM,
        MID_HALF_REM
    } mid_src_t;

    state_t                 state_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [AGG_W-1:0]       agg_reg;
    logic                   up_cnt_reg;
    logic                   down_cnt_reg;
    logic [MID_CNT_W-1:0]   mid_cnt_reg;
    logic                   up_reg, up_next;
    logic                   down_reg, down_next;
    mid_src_t               mid_src_reg, mid_src_next;
    logic [HPR_W-1:0]       host_reg;
    logic                   m_valid_reg;
    msrs_out_t              m_data_reg;

    logic [AGG_W-1:0]       na;
    logic [MID_CNT_W-1:0]   half;
    logic [GROUP_W-1:0]     group_size;
    logic                   accept;
    logic                   div_exit;
    logic                   finish;

    logic                   a_busy, b_busy, c_busy;
    logic [DEST_W-1:0]      a_quo, b_quo;
    logic [GROUP_W-1:0]     a_rem;
    logic [HPR_W-1:0]       b_rem;
    logic [AGG_W-1:0]       c_rem;
    logic                   b_start;
    logic [DEST_W-1:0]      b_dividend;
    logic [RAND_W-1:0]      c_dividend;
    logic [AGG_W-1:0]       c_divisor;
    logic [MID_CNT_W-1:0]   mid_val;
    logic                   mid_adv;

    // Effective aggregation count and derived divisors
    always_comb begin
        na         = (agg_reg < AGG_MIN) ? AGG_MIN : agg_reg;
        half       = na[AGG_W-1:1];
        group_size = GROUP_W'(int'(na) * RACKS_FACTOR);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign div_exit = (state_reg == ST_DIV) && !a_busy && !b_busy;
    assign finish   = (state_reg == ST_RACK) && !b_busy && !c_busy
                      && (!m_valid_reg || m_ready);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            agg_reg  <= AGG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SELECT_MODE: mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_AGG_COUNT:   agg_reg  <= cfg_wr_data[AGG_W-1:0];
            endcase
        end
    end

    // Path choice decode at accept; sets the operands of the mid reducer
    always_comb begin
        up_next      = s_data.random_up_bit;
        down_next    = s_data.random_down_bit;
        mid_src_next = MID_REM;
        c_dividend   = s_data.random_word;
        c_divisor    = {1'b0, half};
        unique case (mode_reg)
            MODE_RR, MODE_SEQ_RR: begin
                // next round robin index = (count + 1) mod half
                up_next      = up_cnt_reg;
                down_next    = down_cnt_reg;
                mid_src_next = MID_COUNT;
                c_dividend   = RAND_W'({1'b0, mid_cnt_reg} + 8'd1);
            end
            MODE_SHARED: begin
                down_next = s_data.random_up_bit;
            end
            MODE_TAG: begin
                if (s_data.tag_present) begin
                    up_next      = s_data.path_tag_value[0];
                    down_next    = s_data.path_tag_value[0];
                    mid_src_next = MID_HALF_REM;
                    c_dividend   = s_data.path_tag_value;
                    c_divisor    = na;
                end
            end
            default: begin
            end
        endcase
    end

    // Host divider: first dest by hosts per rack, then group remainder by it
    assign b_start    = accept || div_exit;
    assign b_dividend = (state_reg == ST_IDLE) ? s_data.dest_host : DEST_W'(a_rem);

    // Group split: dest / (RACKS_FACTOR * na)
    msrs_div #(
        .DIVIDEND_W (DEST_W),
        .DIVISOR_W  (GROUP_W)
    ) u_group_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (s_data.dest_host),
        .divisor   (group_size),
        .busy      (a_busy),
        .quotient  (a_quo),
        .remainder (a_rem)
    );

    msrs_div #(
        .DIVIDEND_W (DEST_W),
        .DIVISOR_W  (HPR_W)
    ) u_host_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (b_start),
        .dividend  (b_dividend),
        .divisor   (HPR_W'(HOSTS_PER_RACK)),
        .busy      (b_busy),
        .quotient  (b_quo),
        .remainder (b_rem)
    );

    // Intermediate reducer: random word, tag or next counter value
    msrs_div #(
        .DIVIDEND_W (RAND_W),
        .DIVISOR_W  (AGG_W)
    ) u_mid_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (c_dividend),
        .divisor   (c_divisor),
        .busy      (c_busy),
        .quotient  (),
        .remainder (c_rem)
    );

    // Intermediate index and counter advance
    always_comb begin
        unique case (mid_src_reg)
            MID_COUNT:    mid_val = mid_cnt_reg;
            MID_REM:      mid_val = c_rem[MID_CNT_W-1:0];
            MID_HALF_REM: mid_val = c_rem[AGG_W-1:1];
            default:      mid_val = c_rem[MID_CNT_W-1:0];
        endcase
        mid_adv = (mode_reg == MODE_RR) || ((mode_reg == MODE_SEQ_RR) && up_cnt_reg);
    end

    // Sequencer, route counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            up_cnt_reg   <= 1'b0;
            down_cnt_reg <= 1'b0;
            mid_cnt_reg  <= '0;
        end else begin
            // drained result word; a new one loaded this cycle takes over
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        up_reg      <= up_next;
                        down_reg    <= down_next;
                        mid_src_reg <= mid_src_next;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_exit) begin
                        host_reg  <= b_rem;
                        state_reg <= ST_RACK;
                    end
                end
                ST_RACK: begin
                    if (finish) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.uplink_port       <=
                            UPLINK_W'(HOSTS_PER_RACK + int'(up_reg));
                        m_data_reg.intermediate_port <= {1'b0, half} + {1'b0, mid_val};
                        m_data_reg.downlink_port     <= {a_quo[DOWNLINK_W-2:0], down_reg};
                        m_data_reg.rack_port         <= b_quo[RACK_W-1:0];
                        m_data_reg.host_port         <= HOST_W'(host_reg);
                        if ((mode_reg == MODE_RR) || (mode_reg == MODE_SEQ_RR)) begin
                            up_cnt_reg   <= ~up_cnt_reg;
                            down_cnt_reg <= ~down_cnt_reg;
                        end
                        if (mid_adv) begin
                            mid_cnt_reg <= c_rem[MID_CNT_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_updown_match: assert property (@(posedge aclk) disable iff (!aresetn)
        up_cnt_reg == down_cnt_reg)
        else $error("round robin up and down counters diverged");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> a_busy && b_busy && c_busy)
        else $error("dividers not started on accepted word");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !b_busy && !c_busy)
        else $error("ready while a divider is still busy");

    a_result_from_rack: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RACK))
        else $error("result word loaded outside the final pass");

endmodule
`default_nettype wire

// ----- dv/tb_multipath_source_route_selector_top.sv -----
// ============================================================================
// tb_multipath_source_route_selector_top
// Self-checking bench for the source route selector. A short table of
// directed packets covers reset behavior, field extremes, all select codes,
// the small aggregation count clamp, a stale middle counter and tagged paths.
// Random packets follow in phases that each use a fresh mode and switch
// count. Every route is predicted at input acceptance and compared field by
// field with the result words in order. Both channels idle at random.
// ============================================================================
module tb_multipath_source_route_selector_top;
    import msrs_pkg::*;

    localparam int HOSTS_PER_RACK = 20;
    localparam int RACKS_FACTOR   = 10;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_WORDS    = 71;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [AGG_W-1:0]  agg;
        msrs_in_t          pkt;
        bit                typed;
        msrs_out_t         route;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    msrs_in_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    msrs_out_t              m_data;

    // Predictor copy of the registers and route counters
    logic [MODE_W-1:0]    sel_mode = MODE_RESET;
    logic [AGG_W-1:0]     agg_count = AGG_RESET;
    logic                 up_rr = 1'b0;
    logic [MID_CNT_W-1:0] mid_rr = '0;
    logic                 down_rr = 1'b0;

    msrs_out_t route_q[$];
    int        fail_count = 0;
    int        rx_hold = 0;
    bit        rx_steady = 1'b0;
    bit        tx_steady = 1'b0;

    multipath_source_route_selector_top #(
        .HOSTS_PER_RACK(HOSTS_PER_RACK),
        .RACKS_FACTOR  (RACKS_FACTOR)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Route for one packet under the current settings; in the round robin modes it advances the counters
    function automatic msrs_out_t next_route(input msrs_in_t p);
        logic [31:0] na, half, grp, up, mid, down, tmp;
        msrs_out_t r;
        na   = (agg_count < AGG_MIN) ? 32'(AGG_MIN) : 32'(agg_count);
        half = na / 2;
        grp  = RACKS_FACTOR * na;
        case (sel_mode)
            MODE_RR, MODE_SEQ_RR: begin
                up   = 32'(up_rr);
                mid  = 32'(mid_rr);
                down = 32'(down_rr);
                // sequential mode steps the middle index only on an up-bit carry
                if (sel_mode == MODE_RR || up_rr) begin
                    tmp = (32'(mid_rr) + 32'd1) % half;
                    mid_rr = tmp[MID_CNT_W-1:0];
                end
                up_rr   = ~up_rr;
                down_rr = ~down_rr;
            end
            MODE_SHARED: begin
                up   = 32'(p.random_up_bit);
                mid  = p.random_word % half;
                down = 32'(p.random_up_bit);
            end
            MODE_TAG: begin
                if (p.tag_present) begin
                    up   = p.path_tag_value % 2;
                    mid  = (p.path_tag_value % na) / 2;
                    down = up;
                end else begin
                    up   = 32'(p.random_up_bit);
                    mid  = p.random_word % half;
                    down = 32'(p.random_down_bit);
                end
            end
            default: begin
                up   = 32'(p.random_up_bit);
                mid  = p.random_word % half;
                down = 32'(p.random_down_bit);
            end
        endcase
        tmp = HOSTS_PER_RACK + up;
        r.uplink_port = tmp[UPLINK_W-1:0];
        tmp = half + mid;
        r.intermediate_port = tmp[INTER_W-1:0];
        tmp = (32'(p.dest_host) / grp) * 2 + down;
        r.downlink_port = tmp[DOWNLINK_W-1:0];
        tmp = (32'(p.dest_host) % grp) / HOSTS_PER_RACK;
        r.rack_port = tmp[RACK_W-1:0];
        tmp = 32'(p.dest_host) % HOSTS_PER_RACK;
        r.host_port = tmp[HOST_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t mk_row(input logic [MODE_W-1:0] mode,
                                        input logic [AGG_W-1:0] agg,
                                        input logic [DEST_W-1:0] dest,
                                        input logic tag_p,
                                        input logic [TAG_W-1:0] tag_v,
                                        input logic rup, input logic rdown,
                                        input logic [RAND_W-1:0] rword,
                                        input bit typed, input msrs_out_t route);
        dir_row_t d;
        d.mode                = mode;
        d.agg                 = agg;
        d.pkt.dest_host       = dest;
        d.pkt.tag_present     = tag_p;
        d.pkt.path_tag_value  = tag_v;
        d.pkt.random_up_bit   = rup;
        d.pkt.random_down_bit = rdown;
        d.pkt.random_word     = rword;
        d.typed               = typed;
        d.route               = route;
        return d;
    endfunction

    function automatic msrs_in_t rand_packet();
        msrs_in_t p;
        case ($urandom_range(0, 9))
            0: p.dest_host = '0;
            1: p.dest_host = '1;
            2: p.dest_host = DEST_W'($urandom_range(0, 255));
            default: p.dest_host = DEST_W'($urandom);
        endcase
        p.tag_present     = 1'($urandom);
        p.path_tag_value  = ($urandom_range(0, 7) == 0) ? {TAG_W{$urandom_range(0, 1) == 1}}
                                                        : $urandom;
        p.random_up_bit   = 1'($urandom);
        p.random_down_bit = 1'($urandom);
        p.random_word     = ($urandom_range(0, 7) == 0) ? {RAND_W{$urandom_range(0, 1) == 1}}
                                                        : $urandom;
        return p;
    endfunction

    // Offer one word, record its route at acceptance, then idle for the given gap
    task automatic offer_packet(input msrs_in_t p, input bit typed,
                                input msrs_out_t route, input int gap);
        msrs_out_t pred;
        s_valid <= 1'b1;
        s_data  <= p;
        do
            @(posedge aclk);
        while (!s_ready);
        pred = next_route(p);
        route_q.push_back(typed ? route : pred);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write both registers once every pending route has come back
    task automatic write_regs(input logic [CFG_DATA_W-1:0] mode_data,
                              input logic [CFG_DATA_W-1:0] agg_data);
        s_valid <= 1'b0;
        while (route_q.size() != 0)
            @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SELECT_MODE;
        cfg_wr_data <= mode_data;
        @(posedge aclk);
        cfg_index   <= REG_AGG_COUNT;
        cfg_wr_data <= agg_data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sel_mode  = mode_data[MODE_W-1:0];
        agg_count = agg_data;
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
                rx_hold <= pick_gap(1'b0);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        msrs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (route_q.size() == 0) begin
                $error("unexpected result word %h", m_data);
                fail_count++;
            end else begin
                want = route_q.pop_front();
                if (m_data.uplink_port !== want.uplink_port) begin
                    $error("uplink_port: expected %0d, got %0d",
                           want.uplink_port, m_data.uplink_port);
                    fail_count++;
                end
                if (m_data.intermediate_port !== want.intermediate_port) begin
                    $error("intermediate_port: expected %0d, got %0d",
                           want.intermediate_port, m_data.intermediate_port);
                    fail_count++;
                end
                if (m_data.downlink_port !== want.downlink_port) begin
                    $error("downlink_port: expected %0d, got %0d",
                           want.downlink_port, m_data.downlink_port);
                    fail_count++;
                end
                if (m_data.rack_port !== want.rack_port) begin
                    $error("rack_port: expected %0d, got %0d",
                           want.rack_port, m_data.rack_port);
                    fail_count++;
                end
                if (m_data.host_port !== want.host_port) begin
                    $error("host_port: expected %0d, got %0d",
                           want.host_port, m_data.host_port);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        dir_row_t          rows[$];
        logic [MODE_W-1:0] mode;
        logic [AGG_W-1:0]  agg;

        // after reset: round robin over two switches, counters at zero
        rows.push_back(mk_row(MODE_RR, 8'd2, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0,
                              1'b1, msrs_out_t'{5'd20, 8'd1, 13'd0, 7'd0, 5'd0}));
        rows.push_back(mk_row(MODE_RR, 8'd2, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1,
                              32'hFFFFFFFF, 1'b1,
                              msrs_out_t'{5'd21, 8'd1, 13'd6553, 7'd0, 5'd15}));
        // walk the middle counter up at the widest fabric
        rows.push_back(mk_row(MODE_RR, 8'd254, 16'd12345, 1'b0, 32'h0, 1'b0, 1'b1, 32'h5,
                              1'b0, '0));
        rows.push_back(mk_row(MODE_RR, 8'd254, 16'hFFFF, 1'b1, 32'h7, 1'b1, 1'b0, 32'h0,
                              1'b0, '0));
        rows.push_back(mk_row(MODE_RR, 8'd254, 16'd2539, 1'b0, 32'h0, 1'b0, 1'b0, 32'h1,
                              1'b0, '0));
        // shrunk fabric: counter beyond the new range is used as it stands
        rows.push_back(mk_row(MODE_RR, 8'd4, 16'd40, 1'b0, 32'h0, 1'b1, 1'b1, 32'h0,
                              1'b0, '0));
        // sequential round robin, middle moves on the carry only
        repeat (4)
            rows.push_back(mk_row(MODE_SEQ_RR, 8'd6, 16'd61, 1'b0, 32'h0, 1'b0, 1'b0,
                                  32'h0, 1'b0, '0));
        // one random bit shared by up and down
        rows.push_back(mk_row(MODE_SHARED, 8'd254, 16'd500, 1'b0, 32'h0, 1'b1, 1'b0,
                              32'hFFFFFFFF, 1'b0, '0));
        rows.push_back(mk_row(MODE_SHARED, 8'd254, 16'd501, 1'b1, 32'h3, 1'b0, 1'b1,
                              32'h80000000, 1'b0, '0));
        // tagged paths, tag absent falls back to random
        rows.push_back(mk_row(MODE_TAG, 8'd254, 16'd7777, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0,
                              32'h0, 1'b0, '0));
        rows.push_back(mk_row(MODE_TAG, 8'd254, 16'd7778, 1'b1, 32'h0, 1'b1, 1'b1,
                              32'hFFFFFFFF, 1'b0, '0));
        rows.push_back(mk_row(MODE_TAG, 8'd253, 16'd9999, 1'b1, 32'h12345678, 1'b0, 1'b1,
                              32'h0, 1'b0, '0));
        rows.push_back(mk_row(MODE_TAG, 8'd253, 16'd9999, 1'b0, 32'h12345678, 1'b1, 1'b0,
                              32'hDEADBEEF, 1'b0, '0));
        // aggregation count below the minimum is clamped to two
        rows.push_back(mk_row(MODE_RANDOM, 8'd0, 16'd0, 1'b0, 32'h0, 1'b1, 1'b0,
                              32'hFFFFFFFF, 1'b1,
                              msrs_out_t'{5'd21, 8'd1, 13'd0, 7'd0, 5'd0}));
        rows.push_back(mk_row(MODE_RANDOM, 8'd1, 16'd19, 1'b1, 32'h1, 1'b0, 1'b1, 32'h7,
                              1'b1, msrs_out_t'{5'd20, 8'd1, 13'd1, 7'd0, 5'd19}));
        // unused select codes act as random
        for (int c = 5; c < 8; c++)
            rows.push_back(mk_row(MODE_W'(c), 8'd10, 16'd4321, 1'b1, 32'h9, 1'b1, 1'b0,
                                  32'h1234, 1'b0, '0));
        rows.push_back(mk_row(MODE_RANDOM, 8'd254, 16'hFFFF, 1'b0, 32'h0, 1'b1, 1'b1,
                              32'hFFFFFFFF, 1'b0, '0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].mode != sel_mode || rows[i].agg != agg_count)
                write_regs({{(CFG_DATA_W-MODE_W){1'b0}}, rows[i].mode}, rows[i].agg);
            offer_packet(rows[i].pkt, rows[i].typed, rows[i].route, pick_gap(1'b0));
        end

        // random phases, each under its own settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = (ph < 8) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 7));
            case (ph % 4)
                0: agg = 8'd254;
                1: agg = AGG_MIN;
                2: agg = AGG_W'($urandom_range(0, 1));
                default: agg = AGG_W'($urandom_range(3, 253));
            endcase
            write_regs({(CFG_DATA_W-MODE_W)'($urandom), mode}, agg);
            tx_steady = (ph % 3 == 2);
            rx_steady <= (ph % 4 == 3);
            for (int k = 0; k < PHASE_WORDS; k++)
                offer_packet(rand_packet(), 1'b0, '0, pick_gap(tx_steady));
        end

        s_valid <= 1'b0;
        rx_steady <= 1'b0;
        while (route_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("multipath_source_route_selector_top verification clean");
        else
            $display("multipath_source_route_selector_top verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("multipath_source_route_selector_top verification failed");
        $finish;
    end

endmodule
